>>> hw/rtl/bvm_pkg.sv
// Shared widths, operation codes and status codes of the byte VM execute unit.
package bvm_pkg;

	localparam int CMD_W    = 4;
	localparam int SRCA_W   = 4;
	localparam int SRCB_W   = 8;
	localparam int DEST_W   = 4;
	localparam int STATUS_W = 2;
	localparam int VALUE_W  = 8;

	localparam logic [CMD_W-1:0] OP_ADD  = 4'd0;
	localparam logic [CMD_W-1:0] OP_SUB  = 4'd1;
	localparam logic [CMD_W-1:0] OP_LDI  = 4'd2;
	localparam logic [CMD_W-1:0] OP_STR  = 4'd3;
	localparam logic [CMD_W-1:0] OP_LDM  = 4'd4;
	localparam logic [CMD_W-1:0] OP_LDA  = 4'd5;
	localparam logic [CMD_W-1:0] OP_STA  = 4'd6;
	localparam logic [CMD_W-1:0] OP_PUSH = 4'd7;
	localparam logic [CMD_W-1:0] OP_POP  = 4'd8;
	localparam logic [CMD_W-1:0] OP_INC  = 4'd9;
	localparam logic [CMD_W-1:0] OP_DEC  = 4'd10;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BADADDR   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

endpackage

>>> hw/rtl/bvm_cmd_if.sv
// Instruction channel: valid/ready handshake with decoded instruction fields.
interface bvm_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [bvm_pkg::CMD_W-1:0]   cmd;
	logic [bvm_pkg::SRCA_W-1:0]  src_a;
	logic [bvm_pkg::SRCB_W-1:0]  src_b;
	logic [bvm_pkg::DEST_W-1:0]  dest;

	modport source (output valid, output cmd, output src_a, output src_b, output dest,
		input ready);
	modport sink (input valid, input cmd, input src_a, input src_b, input dest,
		output ready);
endinterface

>>> hw/rtl/bvm_res_if.sv
// Result channel: valid/ready handshake with status and written byte.
interface bvm_res_if;
	logic                          valid;
	logic                          ready;
	logic [bvm_pkg::STATUS_W-1:0]  status;
	logic [bvm_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output status, output value, input ready);
	modport sink (input valid, input status, input value, output ready);
endinterface

>>> hw/rtl/byte_vm_execute_unit.sv
// Execute unit of a byte VM: register file, data memory and stack in synchronous RAMs.
//
// Usage:
// - instr (sink) takes one decoded instruction per item; res (source) gives one
//   item per instruction with a status code and the byte written (zero on error).
// - Two stages after acceptance: S1 reads the register file (RAM read of the accept
//   edge), forwards pending writes and accesses data memory and stack; S2 holds the
//   memory read data, writes the register file and presents the result.
// - Result: an accepted instruction moves through S1 and then S2, and res is driven
//   from the S2 registers, which hold their values while res is not taken.
// - Throughput: one instruction per cycle unless stalled, set by the single register
//   file write port in S2 and one data memory access per cycle in S1. Register
//   hazards are covered by forwarding from S2 and from the last register write.
// - Stall: while res is valid and not taken, S2 holds and S1 holds; instr.ready
//   stays high only while S1 is empty, so one more item can be taken.
// - Reset: arst_n clears the pipeline, the stack count and the valid bits of the
//   register file and data memory, so both read as zero until written. Stack
//   contents are not cleared; a pop only reads entries an earlier push wrote.
module byte_vm_execute_unit #(
	parameter int REG_COUNT   = 16,
	parameter int DATA_DEPTH  = 256,
	parameter int STACK_DEPTH = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	bvm_cmd_if.sink  instr,
	bvm_res_if.source res
);

	localparam int RI_W     = $clog2(REG_COUNT);
	localparam int DA_W     = $clog2(DATA_DEPTH);
	localparam int SP_W     = $clog2(STACK_DEPTH);
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int VW       = bvm_pkg::VALUE_W;
	localparam int IDX_SPAN = 1 << bvm_pkg::SRCB_W;

	localparam logic [1:0] SEL_ALU = 2'd0;
	localparam logic [1:0] SEL_DM  = 2'd1;
	localparam logic [1:0] SEL_STK = 2'd2;

	// index modulo REG_COUNT, one table entry per 8-bit index value
	function automatic logic [IDX_SPAN*RI_W-1:0] build_mod_lut();
		logic [IDX_SPAN*RI_W-1:0] lut;
		lut = '0;
		for (int i = 0; i < IDX_SPAN; i++) begin
			lut[i*RI_W +: RI_W] = RI_W'(i % REG_COUNT);
		end
		return lut;
	endfunction

	localparam logic [IDX_SPAN*RI_W-1:0] REG_MOD_LUT = build_mod_lut();

	function automatic logic [RI_W-1:0] reg_mod(input logic [7:0] v);
		return REG_MOD_LUT[int'(v)*RI_W +: RI_W];
	endfunction

	// storage
	logic [VW-1:0]          rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0]   rf_vld_q;
	logic [VW-1:0]          dm_mem [DATA_DEPTH];
	logic [DATA_DEPTH-1:0]  dm_vld_q;
	logic [VW-1:0]          stk_mem [STACK_DEPTH];
	logic [CNT_W-1:0]       stk_cnt_q;

	// handshake
	logic adv, in_fire, go1;

	// input index reduction
	logic [RI_W-1:0] in_ra, in_rb, in_rd;

	// stage 1
	logic                      valid_s1;
	logic [bvm_pkg::CMD_W-1:0] cmd_s1;
	logic [RI_W-1:0]           ra_s1, rb_s1, rd_s1;
	logic [7:0]                imm_s1;
	logic [VW-1:0]             rfa_s1, rfb_s1;
	logic                      rfa_vld_s1, rfb_vld_s1;

	// stage 2
	logic                          valid_s2;
	logic [bvm_pkg::STATUS_W-1:0]  status_s2;
	logic [VW-1:0]                 val_s2;
	logic                          wen_s2;
	logic [RI_W-1:0]               widx_s2;
	logic [1:0]                    sel_s2;
	logic [VW-1:0]                 dm_rd_s2;
	logic                          dm_vld_s2;
	logic [VW-1:0]                 stk_rd_s2;
	logic [VW-1:0]                 wdata_s2;

	// last register write, for reads issued on the same edge
	logic            lw_vld_q;
	logic [RI_W-1:0] lw_idx_q;
	logic [VW-1:0]   lw_data_q;

	// stage 1 combinational
	logic [VW-1:0]                 opa, opb;
	logic [bvm_pkg::STATUS_W-1:0]  st_c;
	logic [VW-1:0]                 val_c;
	logic                          wen_c;
	logic [RI_W-1:0]               widx_c;
	logic [1:0]                    sel_c;
	logic                          dm_we_c, dm_re_c, stk_we_c, stk_re_c;
	logic [7:0]                    daddr_c;
	logic                          bad_c;
	logic [DA_W-1:0]               didx;
	logic                          stk_full, stk_empty;
	logic [CNT_W-1:0]              cnt_dec;
	logic                          rf_we;

	assign adv         = !valid_s2 || res.ready;
	assign instr.ready = adv || !valid_s1;
	assign in_fire     = instr.valid && instr.ready;
	assign go1         = valid_s1 && adv;

	assign in_ra = reg_mod({4'd0, instr.src_a});
	assign in_rb = reg_mod(instr.src_b);
	assign in_rd = reg_mod({4'd0, instr.dest});

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (instr.ready) begin
			valid_s1 <= instr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1 <= instr.cmd;
			ra_s1  <= in_ra;
			rb_s1  <= in_rb;
			rd_s1  <= in_rd;
			imm_s1 <= instr.src_b;
		end
	end

	// register file: two synchronous reads at accept, one write from S2
	assign rf_we = valid_s2 && adv && wen_s2;

	always_ff @(posedge clk) begin
		if (rf_we) begin
			rf_mem[widx_s2] <= wdata_s2;
		end
		if (in_fire) begin
			rfa_s1     <= rf_mem[in_ra];
			rfb_s1     <= rf_mem[in_rb];
			rfa_vld_s1 <= rf_vld_q[in_ra];
			rfb_vld_s1 <= rf_vld_q[in_rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q <= '0;
			lw_vld_q <= 1'b0;
		end else if (rf_we) begin
			rf_vld_q[widx_s2] <= 1'b1;
			lw_vld_q          <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			lw_idx_q  <= widx_s2;
			lw_data_q <= wdata_s2;
		end
	end

	// operand forwarding: pending S2 write first, then the write of the read edge
	always_comb begin
		opa = rfa_vld_s1 ? rfa_s1 : '0;
		if (lw_vld_q && lw_idx_q == ra_s1) begin
			opa = lw_data_q;
		end
		if (valid_s2 && wen_s2 && widx_s2 == ra_s1) begin
			opa = wdata_s2;
		end
		opb = rfb_vld_s1 ? rfb_s1 : '0;
		if (lw_vld_q && lw_idx_q == rb_s1) begin
			opb = lw_data_q;
		end
		if (valid_s2 && wen_s2 && widx_s2 == rb_s1) begin
			opb = wdata_s2;
		end
	end

	assign stk_full  = (stk_cnt_q == CNT_W'(STACK_DEPTH));
	assign stk_empty = (stk_cnt_q == '0);
	assign cnt_dec   = stk_cnt_q - 1'b1;

	always_comb begin
		st_c     = bvm_pkg::ST_OK;
		val_c    = '0;
		wen_c    = 1'b0;
		widx_c   = ra_s1;
		sel_c    = SEL_ALU;
		dm_we_c  = 1'b0;
		dm_re_c  = 1'b0;
		stk_we_c = 1'b0;
		stk_re_c = 1'b0;
		daddr_c  = imm_s1;
		if (cmd_s1 == bvm_pkg::OP_LDA || cmd_s1 == bvm_pkg::OP_STA) begin
			daddr_c = opa;
		end
		bad_c = ({1'b0, daddr_c} >= 9'(DATA_DEPTH));
		case (cmd_s1)
			bvm_pkg::OP_ADD: begin
				val_c  = opa + opb;
				wen_c  = 1'b1;
				widx_c = rd_s1;
			end
			bvm_pkg::OP_SUB: begin
				val_c  = opa - opb;
				wen_c  = 1'b1;
				widx_c = rd_s1;
			end
			bvm_pkg::OP_LDI: begin
				val_c = imm_s1;
				wen_c = 1'b1;
			end
			bvm_pkg::OP_STR: begin
				if (bad_c) begin
					st_c = bvm_pkg::ST_BADADDR;
				end else begin
					val_c   = opa;
					dm_we_c = 1'b1;
				end
			end
			bvm_pkg::OP_LDM: begin
				if (bad_c) begin
					st_c = bvm_pkg::ST_BADADDR;
				end else begin
					dm_re_c = 1'b1;
					sel_c   = SEL_DM;
					wen_c   = 1'b1;
				end
			end
			bvm_pkg::OP_LDA: begin
				if (bad_c) begin
					st_c = bvm_pkg::ST_BADADDR;
				end else begin
					dm_re_c = 1'b1;
					sel_c   = SEL_DM;
					wen_c   = 1'b1;
					widx_c  = rb_s1;
				end
			end
			bvm_pkg::OP_STA: begin
				if (bad_c) begin
					st_c = bvm_pkg::ST_BADADDR;
				end else begin
					val_c   = opb;
					dm_we_c = 1'b1;
				end
			end
			bvm_pkg::OP_PUSH: begin
				if (stk_full) begin
					st_c = bvm_pkg::ST_OVERFLOW;
				end else begin
					val_c    = opa;
					stk_we_c = 1'b1;
				end
			end
			bvm_pkg::OP_POP: begin
				if (stk_empty) begin
					st_c = bvm_pkg::ST_UNDERFLOW;
				end else begin
					stk_re_c = 1'b1;
					sel_c    = SEL_STK;
					wen_c    = 1'b1;
				end
			end
			bvm_pkg::OP_INC: begin
				val_c = opa + 1'b1;
				wen_c = 1'b1;
			end
			bvm_pkg::OP_DEC: begin
				val_c = opa - 1'b1;
				wen_c = 1'b1;
			end
			default: begin
				st_c = bvm_pkg::ST_OK;
			end
		endcase
	end

	assign didx = daddr_c[DA_W-1:0];

	// data memory: one access per cycle in S1, valid bits give the zero reset
	always_ff @(posedge clk) begin
		if (go1 && dm_we_c) begin
			dm_mem[didx] <= val_c;
		end
		if (go1 && dm_re_c) begin
			dm_rd_s2  <= dm_mem[didx];
			dm_vld_s2 <= dm_vld_q[didx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dm_vld_q <= '0;
		end else if (go1 && dm_we_c) begin
			dm_vld_q[didx] <= 1'b1;
		end
	end

	// stack: entry at the count is the next free slot
	always_ff @(posedge clk) begin
		if (go1 && stk_we_c) begin
			stk_mem[stk_cnt_q[SP_W-1:0]] <= opa;
		end
		if (go1 && stk_re_c) begin
			stk_rd_s2 <= stk_mem[cnt_dec[SP_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stk_cnt_q <= '0;
		end else if (go1 && stk_we_c) begin
			stk_cnt_q <= stk_cnt_q + 1'b1;
		end else if (go1 && stk_re_c) begin
			stk_cnt_q <= cnt_dec;
		end
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			status_s2 <= st_c;
			val_s2    <= val_c;
			wen_s2    <= wen_c;
			widx_s2   <= widx_c;
			sel_s2    <= sel_c;
		end
	end

	always_comb begin
		case (sel_s2)
			SEL_DM:  wdata_s2 = dm_vld_s2 ? dm_rd_s2 : '0;
			SEL_STK: wdata_s2 = stk_rd_s2;
			default: wdata_s2 = val_s2;
		endcase
	end

	assign res.valid  = valid_s2;
	assign res.status = status_s2;
	assign res.value  = wdata_s2;

`ifndef SYNTHESIS
	a_stk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stk_cnt_q <= CNT_W'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != bvm_pkg::ST_OK |-> res.value == '0)
		else $error("error result carries nonzero value");

	a_push_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		go1 && stk_we_c |=> stk_cnt_q == CNT_W'($past(stk_cnt_q) + 1'b1))
		else $error("push did not advance stack count");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res.ready && valid_s1 |=> valid_s1 && $stable(cmd_s1))
		else $error("S1 moved while output stalled");
`endif

endmodule
